@@ hdl/olte_pkg.sv @@
package olte_pkg;

  // field widths of the request and response payloads
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_PRIOR  = 3'd4,
    CMD_NEXT   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_INDEX    = 3'd1,
    ST_FULL         = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_NO_NEIGHBOUR = 3'd4
  } status_t;

  // per-request sideband carried alongside the search tree
  typedef struct packed {
    cmd_t             cmd;
    status_t          err;
    logic [CNT_W-1:0] count;
    logic             empty;
  } side_t;

endpackage

@@ hdl/olte_if.sv @@
interface olte_req_if;
  logic                       valid;
  logic                       ready;
  logic [olte_pkg::CMD_W-1:0] cmd;
  logic [olte_pkg::IDX_W-1:0] index;
  logic [olte_pkg::VAL_W-1:0] value;

  modport source (output valid, cmd, index, value, input ready);
  modport sink   (input valid, cmd, index, value, output ready);
endinterface

interface olte_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [olte_pkg::STAT_W-1:0] status;
  logic [olte_pkg::VAL_W-1:0]  data;
  logic [olte_pkg::POS_W-1:0]  position;
  logic [olte_pkg::CNT_W-1:0]  count;
  logic                        is_empty;

  modport source (output valid, status, data, position, count, is_empty, input ready);
  modport sink   (input valid, status, data, position, count, is_empty, output ready);
endinterface

@@ hdl/olte_cell.sv @@
module olte_cell #(
  parameter int unsigned POS_IDX    = 0,
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned CW         = 7
) (
  input  logic                  clk,
  input  olte_pkg::cmd_t        cmd,
  input  logic [CW-1:0]         idx,
  input  logic [CW-1:0]         fill,
  input  logic [ELEM_WIDTH-1:0] key,
  input  logic                  ins_en,
  input  logic                  rem_en,
  input  logic [ELEM_WIDTH-1:0] left_entry,
  input  logic [ELEM_WIDTH-1:0] right_entry,
  output logic [ELEM_WIDTH-1:0] entry,
  output logic                  hit,
  output logic                  nb_ok,
  output logic [ELEM_WIDTH-1:0] pick_data
);
  import olte_pkg::*;

  localparam logic [CW-1:0] MY_POS  = CW'(POS_IDX);
  localparam logic [CW:0]   MY_NEXT = (CW+1)'(POS_IDX + 1);

  logic [ELEM_WIDTH-1:0] entry_r;
  logic [ELEM_WIDTH-1:0] entry_nxt;
  logic                  match;

  assign entry = entry_r;
  assign match = (MY_POS < fill) && (entry_r == key);

  // insert: cells above the slot take their left neighbour; remove: take the right one
  always_comb begin
    entry_nxt = entry_r;
    if (ins_en) begin
      if (MY_POS > idx) begin
        entry_nxt = left_entry;
      end else if (MY_POS == idx) begin
        entry_nxt = key;
      end
    end else if (rem_en && (MY_POS >= idx)) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // candidate for the first-hit search
  always_comb begin
    hit       = 1'b0;
    nb_ok     = 1'b1;
    pick_data = entry_r;
    case (cmd)
      CMD_REMOVE, CMD_READ: begin
        hit = (MY_POS == idx);
      end
      CMD_LOCATE: begin
        hit = match;
      end
      CMD_PRIOR: begin
        hit       = match;
        nb_ok     = (POS_IDX != 0);
        pick_data = left_entry;
      end
      CMD_NEXT: begin
        hit       = match;
        nb_ok     = (MY_NEXT < {1'b0, fill});
        pick_data = right_entry;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/ordered_list_table_engine.sv @@
// Response path: the registered first-hit tree over the cells, LV = clog2(CAPACITY)
//   levels above the leaves, then the output response register.
// Throughput: one request per cycle while the response side keeps up; a stalled
//   response freezes the whole pipeline and holds in_req.ready low.
// Reset (rst_n, synchronous, active low): list length to zero, pipeline emptied.
//   Entry storage is not cleared; only positions below the length are ever used.
module ordered_list_table_engine #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  olte_req_if.sink         in_req,
  olte_rsp_if.source       out_rsp
);
  import olte_pkg::*;

  // tree geometry: leaves padded up to a power of two
  localparam int unsigned LV    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned NLEAF = 1 << LV;
  localparam int unsigned NNODE = 2 * NLEAF - 1;
  localparam int unsigned PW    = LV;
  // length / index compare width: holds CAPACITY itself and any raw index
  localparam int unsigned CW    = ($clog2(CAPACITY + 1) > IDX_W) ?
                                  $clog2(CAPACITY + 1) : IDX_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef struct packed {
    logic                  hit;
    logic                  nb;
    logic [PW-1:0]         pos;
    logic [ELEM_WIDTH-1:0] data;
  } node_t;

  // ---------------------------------------------------------------------------
  // Front end: length bookkeeping and error checks, all against the current length
  // ---------------------------------------------------------------------------
  logic          en;
  logic          accept;
  cmd_t          cmd_in;
  logic [CW-1:0] idx_ext;
  logic [ELEM_WIDTH-1:0] key;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;
  status_t       err;
  logic          ins_ok;
  logic          rem_ok;
  logic          ins_en;
  logic          rem_en;
  side_t         side_in;

  logic          out_valid_r;

  // pipeline moves whenever the response register is free or being drained
  assign en           = !out_valid_r || out_rsp.ready;
  assign in_req.ready = en;
  assign accept       = in_req.valid && en;

  assign cmd_in  = cmd_t'(in_req.cmd);
  assign idx_ext = CW'(in_req.index);
  assign key     = ELEM_WIDTH'(in_req.value);   // value taken modulo the element width

  always_comb begin
    err      = ST_OK;
    fill_nxt = fill_r;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    case (cmd_in)
      CMD_INSERT: begin
        // index check takes precedence over full
        if (idx_ext > fill_r) begin
          err = ST_BAD_INDEX;
        end else if (fill_r >= CAP_C) begin
          err = ST_FULL;
        end else begin
          ins_ok   = 1'b1;
          fill_nxt = fill_r + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (idx_ext >= fill_r) begin
          err = ST_BAD_INDEX;
        end else begin
          rem_ok   = 1'b1;
          fill_nxt = fill_r - CW'(1);
        end
      end
      CMD_READ: begin
        if (idx_ext >= fill_r) begin
          err = ST_BAD_INDEX;
        end
      end
      default: begin
        err = ST_OK;
      end
    endcase
  end

  assign ins_en = accept && ins_ok;
  assign rem_en = accept && rem_ok;

  assign side_in.cmd   = cmd_in;
  assign side_in.err   = err;
  assign side_in.count = CNT_W'(fill_nxt);
  assign side_in.empty = (fill_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row: one entry per cell, neighbours wired left/right for shifts
  // ---------------------------------------------------------------------------
  logic [ELEM_WIDTH-1:0] cell_entry [CAPACITY];
  logic                  leaf_hit   [NLEAF];
  logic                  leaf_nb    [NLEAF];
  logic [ELEM_WIDTH-1:0] leaf_data  [NLEAF];

  for (genvar k = 0; k < NLEAF; k++) begin : g_cell
    if (k < CAPACITY) begin : g_live
      logic [ELEM_WIDTH-1:0] left_w;
      logic [ELEM_WIDTH-1:0] right_w;

      if (k == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_entry[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_entry[k+1];
      end

      olte_cell #(
        .POS_IDX    (k),
        .ELEM_WIDTH (ELEM_WIDTH),
        .CW         (CW)
      ) u_cell (
        .clk         (clk),
        .cmd         (cmd_in),
        .idx         (idx_ext),
        .fill        (fill_r),
        .key         (key),
        .ins_en      (ins_en),
        .rem_en      (rem_en),
        .left_entry  (left_w),
        .right_entry (right_w),
        .entry       (cell_entry[k]),
        .hit         (leaf_hit[k]),
        .nb_ok       (leaf_nb[k]),
        .pick_data   (leaf_data[k])
      );
    end else begin : g_pad
      assign leaf_hit[k]  = 1'b0;
      assign leaf_nb[k]   = 1'b0;
      assign leaf_data[k] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // First-hit tree, heap order: node i has children 2i+1 (lower positions) and 2i+2.
  // Every level is registered, including the leaf level.
  // ---------------------------------------------------------------------------
  node_t node_r   [NNODE];
  node_t node_nxt [NNODE];

  always_comb begin
    for (int i = 0; i < NLEAF - 1; i++) begin
      node_nxt[i] = node_r[2*i+1].hit ? node_r[2*i+1] : node_r[2*i+2];
    end
    for (int k = 0; k < NLEAF; k++) begin
      node_nxt[NLEAF-1+k].hit  = leaf_hit[k];
      node_nxt[NLEAF-1+k].nb   = leaf_nb[k];
      node_nxt[NLEAF-1+k].pos  = PW'(k);
      node_nxt[NLEAF-1+k].data = leaf_data[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NNODE; i++) begin
        node_r[i] <= node_nxt[i];
      end
    end
  end

  // sideband and valid track the tree level by level
  side_t       side_r [LV+1];
  logic [LV:0] vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int j = 1; j <= LV; j++) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LV-1:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // Response build from the root and the request's sideband
  // ---------------------------------------------------------------------------
  node_t             root;
  side_t             side_q;
  status_t           status_nxt;
  logic [VAL_W-1:0]  data_nxt;
  logic [POS_W-1:0]  pos_nxt;

  logic [STAT_W-1:0] status_r;
  logic [VAL_W-1:0]  data_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  count_r;
  logic              empty_r;

  assign root   = node_r[0];
  assign side_q = side_r[LV];

  always_comb begin
    status_nxt = side_q.err;
    data_nxt   = '0;
    pos_nxt    = '0;
    case (side_q.cmd)
      CMD_INSERT: begin
        status_nxt = side_q.err;
      end
      CMD_REMOVE, CMD_READ: begin
        if (side_q.err == ST_OK) begin
          data_nxt = VAL_W'(root.data);
        end
      end
      CMD_LOCATE: begin
        if (root.hit) begin
          pos_nxt = POS_W'(root.pos);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      CMD_PRIOR, CMD_NEXT: begin
        if (!root.hit) begin
          status_nxt = ST_NOT_FOUND;
        end else if (!root.nb) begin
          status_nxt = ST_NO_NEIGHBOUR;
        end else begin
          data_nxt = VAL_W'(root.data);
        end
      end
      default: begin
        status_nxt = ST_OK;   // unused codes: plain acknowledge
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      pos_r    <= pos_nxt;
      count_r  <= side_q.count;
      empty_r  <= side_q.empty;
    end
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = status_r;
  assign out_rsp.data     = data_r;
  assign out_rsp.position = pos_r;
  assign out_rsp.count    = count_r;
  assign out_rsp.is_empty = empty_r;

endmodule

@@ hdl/olte_chk.sv @@
module olte_chk #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [olte_pkg::STAT_W-1:0] out_status,
  input logic [olte_pkg::VAL_W-1:0]  out_data,
  input logic [olte_pkg::POS_W-1:0]  out_position,
  input logic [olte_pkg::CNT_W-1:0]  out_count,
  input logic                        out_is_empty
);
  import olte_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // request side only stalls behind a held response
  a_stall_cause: assert property (@(posedge clk)
    !in_ready |-> (out_valid && !out_ready))
    else $error("request stalled without response backpressure");

  // a pending request stays offered until taken
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> in_valid)
    else $error("request withdrawn before accept");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid after reset");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_count == CAP_CNT))
    else $error("full reported while list not at capacity");

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({out_status, out_data, out_position, out_count, out_is_empty})))
    else $error("stalled response changed");

endmodule

bind ordered_list_table_engine olte_chk #(.CAPACITY(CAPACITY)) u_olte_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .out_status   (out_rsp.status),
  .out_data     (out_rsp.data),
  .out_position (out_rsp.position),
  .out_count    (out_rsp.count),
  .out_is_empty (out_rsp.is_empty)
);
